FILE: hw/rtl/circular_fifo_queue_defines.svh
// Assertion macros used by the queue's top-level RTL file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CIRCULAR_FIFO_QUEUE_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cfq_pkg.sv
`default_nettype none

package cfq_pkg;

  // Queue geometry.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  // Command codes carried by the input transfer.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transfer and read the head slot
    logic commit;  // execute the captured command and load the output register
  } cfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } cfq_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/circular_fifo_queue.sv
// Ring-buffer queue of signed 32-bit words with push, pop and peek commands.
// Input channel: in_valid/in_stall with in_cmd (0 push, 1 pop, 2 peek) and
// in_push_value, which only a push uses. A code of 3 does nothing.
// Result channel: out_valid/out_stall with out_ok, out_data_out, out_count,
// out_is_full and out_is_empty. Every command yields exactly one result.
// A refused push (queue full) or refused pop/peek (queue empty) reports
// out_ok low and a zero data word; count and flags are always reported.
// A transfer accepted at a clock edge is captured together with a read of the
// head slot; the command executes once the output register is free, and its
// result is then registered there. The block holds in_stall high while a
// command is in flight, since a pop or peek reads the slot memory through a
// registered read port before it can execute.
// The result sits in an output register, so the next command is taken while
// an earlier result still waits. If the receiver stalls, the pending command
// waits for the output register and in_stall stays high.
// Reset (rst_n low, synchronous) empties the queue and drops any result;
// slot contents are not cleared and are only used after a push wrote them.
`default_nettype none
`include "circular_fifo_queue_defines.svh"

module circular_fifo_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic signed [cfq_pkg::DATA_W-1:0]  in_push_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_ok,
  output logic signed [cfq_pkg::DATA_W-1:0]       out_data_out,
  output logic [cfq_pkg::CNT_W-1:0]               out_count,
  output logic                                    out_is_full,
  output logic                                    out_is_empty
);
  import cfq_pkg::*;

  cfq_cmd_t  cmd;
  cfq_stat_t stat;

  // Sequencing of each command.
  cfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot memory, pointers and output register.
  cfq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_data_out  (out_data_out),
    .out_count     (out_count),
    .out_is_full   (out_is_full),
    .out_is_empty  (out_is_empty)
  );

  // An accepted transfer keeps the input side busy in the next cycle.
  `CFQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
  // A refused or unused command reports a zero data word.
  `CFQ_ASSERT_SAME(a_refused_zero, out_valid && !out_ok, out_data_out == '0, "refused data not 0")
  // The empty flag agrees with the reported count.
  `CFQ_ASSERT_SAME(a_empty_flag, out_valid, out_is_empty == (out_count == '0), "empty flag wrong")
  // Commands only execute after a transfer was captured.
  `CFQ_ASSERT_SAME(a_commit_busy, cmd.commit, in_stall, "commit while idle")

endmodule

`default_nettype wire

FILE: hw/rtl/cfq_ctrl.sv
`default_nettype none

module cfq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cfq_pkg::cfq_stat_t stat,
  output cfq_pkg::cfq_cmd_t      cmd
);
  import cfq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // The block takes a new transfer only while no command is in flight.
  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit = (state_r == ST_EXEC) && stat.out_free;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cfq_dp.sv
`default_nettype none

module cfq_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cfq_pkg::cfq_cmd_t                  cmd,
  output cfq_pkg::cfq_stat_t                      stat,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic signed [cfq_pkg::DATA_W-1:0]  in_push_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_ok,
  output logic signed [cfq_pkg::DATA_W-1:0]       out_data_out,
  output logic [cfq_pkg::CNT_W-1:0]               out_count,
  output logic                                    out_is_full,
  output logic                                    out_is_empty
);
  import cfq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  // Slot storage and its registered read port.
  logic [DATA_W-1:0] slots_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Captured command.
  logic [1:0]        cmd_r;
  logic [DATA_W-1:0] value_r;

  // Queue pointers and occupancy.
  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] head_nxt;
  logic [IDX_W-1:0] tail_r;
  logic [IDX_W-1:0] tail_nxt;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;

  // Write port controls.
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Result of the current command.
  logic              ok;
  logic [DATA_W-1:0] data;
  logic              full;
  logic              empty;

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_ok_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_full_r;
  logic              out_empty_r;

  assign full  = (occ_r == FULL_CNT);
  assign empty = (occ_r == '0);

  // Execute the captured command against the current queue state.
  always_comb begin
    ok       = 1'b0;
    data     = '0;
    wr_en    = 1'b0;
    wr_addr  = tail_r;
    wr_data  = value_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    case (cmd_r)
      OP_PUSH: begin
        if (!full) begin
          ok       = 1'b1;
          wr_en    = 1'b1;
          tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          occ_nxt  = occ_r + 1'b1;
        end
      end
      OP_POP: begin
        if (!empty) begin
          ok       = 1'b1;
          data     = rd_data_r;
          wr_en    = 1'b1;
          wr_addr  = head_r;
          wr_data  = '0;
          head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          occ_nxt  = occ_r - 1'b1;
        end
      end
      OP_PEEK: begin
        if (!empty) begin
          ok   = 1'b1;
          data = rd_data_r;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Slot memory: the head is read when a transfer is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= slots_r[head_r];
    end
    if (cmd.commit && wr_en) begin
      slots_r[wr_addr] <= wr_data;
    end
  end

  // Capture the accepted transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      value_r <= in_push_value;
    end
  end

  // Pointer and occupancy registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else if (cmd.commit) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // Output register: free when empty or when its result leaves this cycle.
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok_r    <= ok;
      out_data_r  <= data;
      out_count_r <= occ_nxt;
      out_full_r  <= (occ_nxt == FULL_CNT);
      out_empty_r <= (occ_nxt == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_data_out = out_data_r;
  assign out_count    = out_count_r;
  assign out_is_full  = out_full_r;
  assign out_is_empty = out_empty_r;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import cfq_pkg::*;

  // The one command code that the queue leaves unused.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_FROM = 370;
  localparam int LONG_HOLD = 40;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  // One result of the queue, field by field.
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
    logic                     full;
    logic                     empty;
  } qresult_t;

  // One row of the directed table; a typed row carries its own result.
  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] word;
    bit                       typed;
    qresult_t                 want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_cmd;
  logic signed [DATA_W-1:0] in_push_value;
  logic out_valid;
  logic out_stall;
  logic out_ok;
  logic signed [DATA_W-1:0] out_data_out;
  logic [CNT_W-1:0] out_count;
  logic out_is_full;
  logic out_is_empty;

  // Shadow copy of the ring buffer.
  logic signed [DATA_W-1:0] shadow_slots [DEPTH];
  int head_pos;
  int tail_pos;
  int fill_level;

  qresult_t pending_results[$];
  cmd_row_t directed_rows[$];
  int errors;
  int results_seen;
  int n_push, n_pop, n_peek, n_refused, n_unused, n_full, n_empty;
  bit calm;
  bit long_hold_req;

  circular_fifo_queue dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_data_out  (out_data_out),
    .out_count     (out_count),
    .out_is_full   (out_is_full),
    .out_is_empty  (out_is_empty)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow queue and returns the result it yields.
  function automatic qresult_t queue_step(logic [1:0] cmd, logic signed [DATA_W-1:0] word);
    qresult_t r;
    r = '0;
    case (cmd)
      OP_PUSH: begin
        if (fill_level < DEPTH) begin
          shadow_slots[tail_pos] = word;
          tail_pos = (tail_pos == DEPTH - 1) ? 0 : tail_pos + 1;
          fill_level++;
          r.ok = 1'b1;
          n_push++;
        end
      end
      OP_POP: begin
        if (fill_level != 0) begin
          r.data = shadow_slots[head_pos];
          shadow_slots[head_pos] = '0;
          head_pos = (head_pos == DEPTH - 1) ? 0 : head_pos + 1;
          fill_level--;
          r.ok = 1'b1;
          n_pop++;
        end
      end
      OP_PEEK: begin
        if (fill_level != 0) begin
          r.data = shadow_slots[head_pos];
          r.ok = 1'b1;
          n_peek++;
        end
      end
      default: n_unused++;
    endcase
    if (!r.ok && cmd != CMD_UNUSED) n_refused++;
    r.count = fill_level[CNT_W-1:0];
    r.full = (fill_level == DEPTH);
    r.empty = (fill_level == 0);
    if (r.full) n_full++;
    if (r.empty) n_empty++;
    return r;
  endfunction

  // Offers one command until the queue takes it, records the expected result,
  // then sometimes leaves the input idle for a short burst.
  task automatic send_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] word,
                              input bit typed, input qresult_t typed_res);
    qresult_t predicted;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_push_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = queue_step(cmd, word);
    pending_results.push_back(typed ? typed_res : predicted);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic signed [DATA_W-1:0] word,
                         input bit typed, input logic ok, input logic signed [DATA_W-1:0] data,
                         input int count, input logic full, input logic empty);
    cmd_row_t row;
    row.cmd = cmd;
    row.word = word;
    row.typed = typed;
    row.want = '{ok: ok, data: data, count: count[CNT_W-1:0], full: full, empty: empty};
    directed_rows.push_back(row);
  endtask

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request, none near the end.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    qresult_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: ok=%0b data=%0d count=%0d",
                 $time, out_ok, out_data_out, out_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %0b, got %0b", $time, want.ok, out_ok);
          errors++;
        end
        if (out_data_out !== want.data) begin
          $display("%0t: data_out expected %0d, got %0d", $time, want.data, out_data_out);
          errors++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count expected %0d, got %0d", $time, want.count, out_count);
          errors++;
        end
        if (out_is_full !== want.full) begin
          $display("%0t: is_full expected %0b, got %0b", $time, want.full, out_is_full);
          errors++;
        end
        if (out_is_empty !== want.empty) begin
          $display("%0t: is_empty expected %0b, got %0b", $time, want.empty, out_is_empty);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random command streams.
  initial begin
    int mode;
    int roll;
    int push_cut, pop_cut, peek_cut;
    logic [1:0] cmd;
    logic signed [DATA_W-1:0] word;
    errors = 0;
    results_seen = 0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    head_pos = 0;
    tail_pos = 0;
    fill_level = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= OP_PUSH;
    in_push_value <= '0;

    // Refusals on an empty queue, the extreme words, the unused code,
    // filling to the brim, a refused push when full and a pop afterwards.
    add_row(OP_POP, 32'sd0, 1'b1, 1'b0, 0, 0, 1'b0, 1'b1);
    add_row(OP_PEEK, 32'sd0, 1'b1, 1'b0, 0, 0, 1'b0, 1'b1);
    add_row(CMD_UNUSED, WORD_MAX, 1'b1, 1'b0, 0, 0, 1'b0, 1'b1);
    add_row(OP_PUSH, WORD_MAX, 1'b1, 1'b1, 0, 1, 1'b0, 1'b0);
    add_row(OP_PEEK, 32'sd0, 1'b1, 1'b1, WORD_MAX, 1, 1'b0, 1'b0);
    add_row(OP_POP, 32'sd0, 1'b1, 1'b1, WORD_MAX, 0, 1'b0, 1'b1);
    add_row(OP_PUSH, WORD_MIN, 1'b1, 1'b1, 0, 1, 1'b0, 1'b0);
    add_row(OP_PUSH, -32'sd1, 1'b1, 1'b1, 0, 2, 1'b0, 1'b0);
    add_row(OP_PUSH, 32'sd0, 1'b1, 1'b1, 0, 3, 1'b0, 1'b0);
    add_row(CMD_UNUSED, 32'sh5A5A_A5A5, 1'b1, 1'b0, 0, 3, 1'b0, 1'b0);
    for (int k = 0; k < DEPTH - 4; k++)
      add_row(OP_PUSH, (k % 2) ? 32'shAAAA_AAAA : 32'sh5555_5555, 1'b0, 1'b0, 0, 0,
              1'b0, 1'b0);
    add_row(OP_PUSH, 32'sh1234_5678, 1'b1, 1'b1, 0, DEPTH, 1'b1, 1'b0);
    add_row(OP_PUSH, WORD_MAX, 1'b1, 1'b0, 0, DEPTH, 1'b1, 1'b0);
    add_row(OP_POP, 32'sd0, 1'b1, 1'b1, WORD_MIN, DEPTH - 1, 1'b0, 1'b0);
    add_row(OP_PEEK, 32'sd0, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_command(directed_rows[k].cmd, directed_rows[k].word,
                   directed_rows[k].typed, directed_rows[k].want);

    // Random part: fill-heavy, drain-heavy and balanced stretches in turn.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      if (i == 100) long_hold_req = 1'b1;
      if (!calm && i % 120 == 60) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      mode = (i / 30) % 3;
      case (mode)
        0: begin push_cut = 70; pop_cut = 85; peek_cut = 95; end
        1: begin push_cut = 20; pop_cut = 85; peek_cut = 95; end
        default: begin push_cut = 40; pop_cut = 80; peek_cut = 95; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_cut) cmd = OP_PUSH;
      else if (roll < pop_cut) cmd = OP_POP;
      else if (roll < peek_cut) cmd = OP_PEEK;
      else cmd = CMD_UNUSED;
      case ($urandom_range(0, 9))
        0: word = WORD_MAX;
        1: word = WORD_MIN;
        2: word = '0;
        3: word = -32'sd1;
        default: word = $urandom;
      endcase
      send_command(cmd, word, 1'b0, '0);
    end

    // Let the last results drain.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d results checked: %0d pushes, %0d pops, %0d peeks accepted",
             results_seen, n_push, n_pop, n_peek);
    $display("tb: %0d refused, %0d unused codes, full after %0d and empty after %0d transfers",
             n_refused, n_unused, n_full, n_empty);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
